// ----- rtl/owa_pkg.sv -----
// ----------------------------------------------------------------------------
// owa_pkg
// Shared types and constants for the one-way ANOVA F statistic block.
// ----------------------------------------------------------------------------
package owa_pkg;

  localparam int MAX_GROUPS        = 16;
  localparam int MAX_GROUP_SAMPLES = 4095;

  localparam int GCNT_W  = $clog2(MAX_GROUPS + 2);
  localparam int MCAND_W = 48;
  localparam int MPLR_W  = 40;
  localparam int PROD_W  = MCAND_W + MPLR_W;
  localparam int DVD_W   = 80;
  localparam int DVS_W   = 64;
  localparam int CNT_W   = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_SINGLE   = 2'd1,
    ERR_ZERO_MSW = 2'd2,
    ERR_TOO_MANY = 2'd3
  } err_t;

  typedef struct packed {
    logic [11:0]        sample_count;
    logic signed [23:0] group_mean;
    logic [23:0]        group_std_dev;
    logic               last_group;
  } in_item_t;

  typedef struct packed {
    logic [31:0] f_ratio;
    logic [63:0] between_sum_squares;
    logic [63:0] within_sum_squares;
    logic [3:0]  between_freedom;
    logic [15:0] within_freedom;
    logic [63:0] between_mean_square;
    logic [63:0] within_mean_square;
    logic [1:0]  error_code;
  } out_item_t;

endpackage

// ----- rtl/one_way_anova_f_statistic.sv -----
// ----------------------------------------------------------------------------
// one_way_anova_f_statistic
// Accumulates group summaries and emits sums of squares, mean squares and F.
// ----------------------------------------------------------------------------
//  channel | ports                    | flow
//  input   | start, busy, in_item     | accepted when start && !busy
//  result  | out_valid, out_item      | one-cycle strobe, no backpressure
//
//  A group runs five bit-serial shift-add multiplies. A last group adds
//  one square and up to four restoring divisions, all divisions on one
//  shared serial divider. busy is high while a group is worked on and,
//  after a last group, until the result strobe; reset (rst_n, synchronous)
//  clears all accumulators. Results cannot be stalled.
// ----------------------------------------------------------------------------
module one_way_anova_f_statistic
  import owa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M_NM, ST_M_AA, ST_M_NS, ST_M_SD, ST_M_NW, ST_FIN, ST_M_SQ,
    ST_D_Q, ST_SSB, ST_MW, ST_D_MB, ST_D_MW, ST_CHK, ST_D_F
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [GCNT_W-1:0]  g_r;
  logic [15:0]        n_tot_r;
  logic signed [39:0] s1_r;
  logic [63:0]        s2_r;
  logic [63:0]        w_r;
  logic [11:0]        n_r;
  logic [11:0]        nm1_r;
  logic [23:0]        am_r;
  logic               neg_r;
  logic [23:0]        sd_r;
  logic               last_r;
  logic [MCAND_W-1:0] mcand_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W-1:0]   rem_r;
  logic [63:0]        q_r;
  logic [63:0]        ssb_r;
  logic [GCNT_W-1:0]  dfb_r;
  logic [15:0]        dfw_r;
  logic [63:0]        msb_r;
  logic [63:0]        msw_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [MCAND_W:0]     mul_sum;
  logic [PROD_W-1:0]    prod_step;
  logic [DVS_W:0]       rem_sh;
  logic                 div_ge;
  logic [DVS_W-1:0]     rem_step;
  logic [DVD_W-1:0]     dvd_step;
  logic signed [40:0]   s1_sum;
  logic signed [39:0]   s1_sat;
  logic [16:0]          n_sum;
  logic [64:0]          s2_sum;
  logic [64:0]          w_sum;
  logic [39:0]          a_abs;
  logic [63:0]          ssb_c;
  logic [15:0]          dfw_c;
  logic [GCNT_W-1:0]    g_inc;
  logic [11:0]          n_in;
  logic [23:0]          am_in;
  logic                 mul_done;
  logic                 div_done;

  always_comb begin
    mul_sum   = {1'b0, prod_r[PROD_W-1:MPLR_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_step = {mul_sum, prod_r[MPLR_W-1:1]};
    rem_sh    = {rem_r, dvd_r[DVD_W-1]};
    div_ge    = rem_sh >= {1'b0, dvs_r};
    rem_step  = div_ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    dvd_step  = {dvd_r[DVD_W-2:0], div_ge};
    mul_done  = cnt_r == CNT_W'(MPLR_W - 1);
    div_done  = cnt_r == CNT_W'(DVD_W - 1);
    s1_sum    = {s1_r[39], s1_r} +
                (neg_r ? -$signed({5'b0, prod_step[35:0]}) : $signed({5'b0, prod_step[35:0]}));
    if (s1_sum[40] != s1_sum[39]) begin
      s1_sat = s1_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end else begin
      s1_sat = s1_sum[39:0];
    end
    n_sum  = {1'b0, n_tot_r} + {5'b0, n_r};
    s2_sum = {1'b0, s2_r} + {1'b0, prod_step[63:0]};
    w_sum  = {1'b0, w_r} + {1'b0, prod_step[63:0]};
    a_abs  = s1_r[39] ? 40'(-s1_r) : 40'(s1_r);
    ssb_c  = (s2_r > q_r) ? s2_r - q_r : '0;
    dfw_c  = (n_tot_r > 16'(g_r)) ? n_tot_r - 16'(g_r) : '0;
    g_inc  = g_r + GCNT_W'(1);
    n_in   = (32'(in_item.sample_count) > MAX_GROUP_SAMPLES) ?
             12'(MAX_GROUP_SAMPLES) : in_item.sample_count;
    am_in  = in_item.group_mean[23] ? 24'(-in_item.group_mean) : 24'(in_item.group_mean);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      g_r         <= '0;
      n_tot_r     <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      cnt_r       <= cnt_r + CNT_W'(1);
      if (state_r == ST_M_NM || state_r == ST_M_AA || state_r == ST_M_NS ||
          state_r == ST_M_SD || state_r == ST_M_NW || state_r == ST_M_SQ) begin
        prod_r <= prod_step;
      end
      if (state_r == ST_D_Q || state_r == ST_D_MB || state_r == ST_D_MW ||
          state_r == ST_D_F) begin
        dvd_r <= dvd_step;
        rem_r <= rem_step;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            n_r    <= n_in;
            nm1_r  <= (n_in == '0) ? '0 : n_in - 12'd1;
            am_r   <= am_in;
            neg_r  <= in_item.group_mean[23];
            sd_r   <= in_item.group_std_dev;
            last_r <= in_item.last_group;
            cnt_r  <= '0;
            state_r <= ST_FIN;
            if (g_r <= GCNT_W'(MAX_GROUPS)) begin
              g_r <= g_inc;
              if (g_inc <= GCNT_W'(MAX_GROUPS)) begin
                mcand_r <= MCAND_W'(am_in);
                prod_r  <= PROD_W'(n_in);
                state_r <= ST_M_NM;
              end
            end
            if (!in_item.last_group && state_r == ST_IDLE &&
                !(g_r <= GCNT_W'(MAX_GROUPS) && g_inc <= GCNT_W'(MAX_GROUPS))) begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_M_NM: begin
          if (mul_done) begin
            s1_r    <= s1_sat;
            n_tot_r <= n_sum[16] ? 16'hFFFF : n_sum[15:0];
            mcand_r <= MCAND_W'(am_r);
            prod_r  <= PROD_W'(am_r);
            cnt_r   <= '0;
            state_r <= ST_M_AA;
          end
        end
        ST_M_AA: begin
          if (mul_done) begin
            mcand_r <= prod_step[MCAND_W-1:0];
            prod_r  <= PROD_W'(n_r);
            cnt_r   <= '0;
            state_r <= ST_M_NS;
          end
        end
        ST_M_NS: begin
          if (mul_done) begin
            s2_r    <= s2_sum[64] ? '1 : s2_sum[63:0];
            mcand_r <= MCAND_W'(sd_r);
            prod_r  <= PROD_W'(sd_r);
            cnt_r   <= '0;
            state_r <= ST_M_SD;
          end
        end
        ST_M_SD: begin
          if (mul_done) begin
            mcand_r <= prod_step[MCAND_W-1:0];
            prod_r  <= PROD_W'(nm1_r);
            cnt_r   <= '0;
            state_r <= ST_M_NW;
          end
        end
        ST_M_NW: begin
          if (mul_done) begin
            w_r     <= w_sum[64] ? '1 : w_sum[63:0];
            state_r <= last_r ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          if (g_r > GCNT_W'(MAX_GROUPS)) begin
            out_r       <= '0;
            out_r.error_code <= ERR_TOO_MANY;
            out_valid_r <= 1'b1;
            g_r <= '0; n_tot_r <= '0; s1_r <= '0; s2_r <= '0; w_r <= '0;
            state_r     <= ST_IDLE;
          end else begin
            mcand_r <= MCAND_W'(a_abs);
            prod_r  <= PROD_W'(a_abs);
            cnt_r   <= '0;
            state_r <= ST_M_SQ;
          end
        end
        ST_M_SQ: begin
          if (mul_done) begin
            cnt_r <= '0;
            if (n_tot_r != '0) begin
              dvd_r   <= prod_step[DVD_W-1:0];
              dvs_r   <= DVS_W'(n_tot_r);
              rem_r   <= '0;
              state_r <= ST_D_Q;
            end else begin
              q_r     <= '0;
              state_r <= ST_SSB;
            end
          end
        end
        ST_D_Q: begin
          if (div_done) begin
            q_r     <= (dvd_step[DVD_W-1:64] != '0) ? '1 : dvd_step[63:0];
            state_r <= ST_SSB;
          end
        end
        ST_SSB: begin
          ssb_r <= ssb_c;
          dfb_r <= (g_r != '0) ? g_r - GCNT_W'(1) : '0;
          dfw_r <= dfw_c;
          cnt_r <= '0;
          if (g_r > GCNT_W'(1)) begin
            dvd_r   <= DVD_W'(ssb_c);
            dvs_r   <= DVS_W'(g_r - GCNT_W'(1));
            rem_r   <= '0;
            state_r <= ST_D_MB;
          end else begin
            msb_r   <= '0;
            state_r <= ST_MW;
          end
        end
        ST_D_MB: begin
          if (div_done) begin
            msb_r   <= dvd_step[63:0];
            state_r <= ST_MW;
          end
        end
        ST_MW: begin
          cnt_r <= '0;
          if (dfw_r != '0) begin
            dvd_r   <= DVD_W'(w_r);
            dvs_r   <= DVS_W'(dfw_r);
            rem_r   <= '0;
            state_r <= ST_D_MW;
          end else begin
            msw_r   <= '0;
            state_r <= ST_CHK;
          end
        end
        ST_D_MW: begin
          if (div_done) begin
            msw_r   <= dvd_step[63:0];
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          cnt_r <= '0;
          out_r.between_sum_squares <= ssb_r;
          out_r.within_sum_squares  <= w_r;
          out_r.between_freedom     <= 4'(dfb_r);
          out_r.within_freedom      <= dfw_r;
          out_r.between_mean_square <= msb_r;
          out_r.within_mean_square  <= msw_r;
          out_r.f_ratio             <= '0;
          if (g_r < GCNT_W'(2) || msw_r == '0) begin
            out_r.error_code <= (g_r < GCNT_W'(2)) ? ERR_SINGLE : ERR_ZERO_MSW;
            out_valid_r <= 1'b1;
            g_r <= '0; n_tot_r <= '0; s1_r <= '0; s2_r <= '0; w_r <= '0;
            state_r     <= ST_IDLE;
          end else begin
            dvd_r   <= {msb_r, 16'b0};
            dvs_r   <= msw_r;
            rem_r   <= '0;
            state_r <= ST_D_F;
          end
        end
        ST_D_F: begin
          if (div_done) begin
            out_r.f_ratio    <= (dvd_step[DVD_W-1:32] != '0) ? '1 : dvd_step[31:0];
            out_r.error_code <= ERR_OK;
            out_valid_r <= 1'b1;
            g_r <= '0; n_tot_r <= '0; s1_r <= '0; s2_r <= '0; w_r <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (g_r == '0 && n_tot_r == '0)) else $error("accumulators not cleared");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.last_group || g_r <= GCNT_W'(MAX_GROUPS - 1))) |=> busy)
    else $error("accepted beat did not start work");
  a_too_many_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.error_code == ERR_TOO_MANY) |->
    (out_item.f_ratio == '0 && out_item.between_sum_squares == '0))
    else $error("too-many-groups result carries data");
`endif

endmodule
